### src/atfc_pkg.sv
// ----------------------------------------------------------------------------
// atfc_pkg
// Shared types and constants for the allocation tracker and free checker.
// ----------------------------------------------------------------------------
package atfc_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int AddrW      = 48;
  localparam int SizeW      = 32;
  localparam int TallyW     = 16;

  typedef enum logic [2:0] {
    OP_ALLOC       = 3'd0,
    OP_FREE        = 3'd1,
    OP_CHECK_PTR   = 3'd2,
    OP_CHECK_RANGE = 3'd3,
    OP_CLEAR       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DOUBLE  = 2'd1,
    ERR_INVALID = 2'd2,
    ERR_FULL    = 2'd3
  } err_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] block_size;
  } in_t;

  typedef struct packed {
    logic              ok;
    err_e              error_kind;
    logic [TallyW-1:0] errors_seen;
  } out_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] length;
    logic             freed;
  } record_t;

  localparam int RecW = $bits(record_t);

endpackage

### src/allocation_tracker_free_checker_core.sv
// ----------------------------------------------------------------------------
// allocation_tracker_free_checker_core
// Table of allocation records with double-free / invalid-free detection and
// pointer / range validity queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | input     | in_valid / stall   | in_t  (op, address, size)
//  out     | output    | out_valid / stall  | out_t (ok, kind, errors)
//  cfg     | input     | cfg_valid / ready  | free_check_enable bit
//
//  Allocate, clear and trivially decided operations answer without a walk.
//  Free and the two queries walk the table newest to oldest through the
//  record RAM read port, one record per cycle, and stop at the first hit.
//  Reset clears the fill count, the error count and sets the enable bit;
//  the record RAM needs no clearing, only filled entries are read.
//  A result waits in the output register; a new transaction is taken
//  while the previous result is leaving.
// ----------------------------------------------------------------------------
module allocation_tracker_free_checker_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  atfc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output atfc_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  import atfc_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic              state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [AddrW:0]    qend_q, qend_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [TallyW-1:0] tally_q, tally_d;
  logic              en_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              cmp_v_q, cmp_v_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              in_accept;
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr;
  record_t           ram_wdata, rd_rec;
  logic [RecW-1:0]   ram_rdata;
  logic [TallyW-1:0] tally_sat;
  logic [AddrW:0]    rec_end;
  logic              addr_eq, range_hit, hit;
  logic              done, res_ok;
  err_e              res_kind;

  atfc_ram #(
    .Width(RecW),
    .Depth(TableDepth)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_rec    = record_t'(ram_rdata);
  assign in_accept = in_valid_i && !in_stall_o;
  assign tally_sat = (tally_q == '1) ? tally_q : tally_q + 1'b1;

  // shared compare unit, one record per cycle
  assign rec_end   = {1'b0, rd_rec.start} + {{(AddrW + 1 - SizeW){1'b0}}, rd_rec.length};
  assign addr_eq   = (rd_rec.start == addr_q);
  assign range_hit = !rd_rec.freed && (addr_q >= rd_rec.start) && (qend_q <= rec_end);

  always_comb begin
    case (op_q)
      OP_FREE:        hit = addr_eq;
      OP_CHECK_PTR:   hit = addr_eq && !rd_rec.freed;
      OP_CHECK_RANGE: hit = range_hit;
      default:        hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    addr_d    = addr_q;
    qend_d    = qend_q;
    used_d    = used_q;
    tally_d   = tally_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    cmp_v_d   = cmp_v_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = used_q[IdxW-1:0];
    ram_wdata = '{start: in_data_i.address, length: in_data_i.block_size, freed: 1'b0};
    done      = 1'b0;
    res_ok    = 1'b0;
    res_kind  = ERR_NONE;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          op_d    = in_data_i.op;
          addr_d  = in_data_i.address;
          qend_d  = {1'b0, in_data_i.address}
                  + {{(AddrW + 1 - SizeW){1'b0}}, in_data_i.block_size};
          idx_d   = IdxW'(used_q - 1'b1);
          cmp_v_d = 1'b0;
          done    = 1'b1;
          case (in_data_i.op)
            OP_ALLOC: begin
              if (in_data_i.address == '0 || in_data_i.block_size == '0) begin
                res_ok = 1'b0;
              end else if (!en_q) begin
                res_ok = 1'b1;
              end else if (used_q == CntW'(TableDepth)) begin
                res_kind = ERR_FULL;
              end else begin
                ram_we = 1'b1;
                used_d = used_q + 1'b1;
                res_ok = 1'b1;
              end
            end
            OP_FREE: begin
              if (in_data_i.address == '0) begin
                res_ok = 1'b0;
              end else if (!en_q) begin
                res_ok = 1'b1;
              end else if (used_q == '0) begin
                res_kind = ERR_INVALID;
                tally_d  = tally_sat;
              end else begin
                done    = 1'b0;
                state_d = StScan;
              end
            end
            OP_CHECK_PTR: begin
              if (in_data_i.address != '0 && used_q != '0) begin
                done    = 1'b0;
                state_d = StScan;
              end
            end
            OP_CHECK_RANGE: begin
              if (in_data_i.address != '0 && in_data_i.block_size != '0 && used_q != '0) begin
                done    = 1'b0;
                state_d = StScan;
              end
            end
            OP_CLEAR: begin
              tally_d = '0;
              res_ok  = 1'b1;
            end
            default: res_ok = 1'b0;
          endcase
        end
      end
      StScan: begin
        // read the next record while comparing the one fetched last cycle
        ram_re    = 1'b1;
        cmp_idx_d = idx_q;
        idx_d     = idx_q - 1'b1;
        cmp_v_d   = 1'b1;
        if (cmp_v_q) begin
          if (hit) begin
            done    = 1'b1;
            state_d = StIdle;
            if (op_q == OP_FREE) begin
              if (rd_rec.freed) begin
                res_kind = ERR_DOUBLE;
                tally_d  = tally_sat;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cmp_idx_q;
                ram_wdata = '{start: rd_rec.start, length: rd_rec.length, freed: 1'b1};
                res_ok    = 1'b1;
              end
            end else begin
              res_ok = 1'b1;
            end
          end else if (cmp_idx_q == '0) begin
            done    = 1'b1;
            state_d = StIdle;
            if (op_q == OP_FREE) begin
              res_kind = ERR_INVALID;
              tally_d  = tally_sat;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_d       = '{ok: res_ok, error_kind: res_kind, errors_seen: tally_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      tally_q     <= '0;
      en_q        <= 1'b1;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      tally_q     <= tally_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    addr_q    <= addr_d;
    qend_q    <= qend_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q == StScan) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

### src/atfc_ram.sv
// ----------------------------------------------------------------------------
// atfc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module atfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/atfc_checker.sv
// ----------------------------------------------------------------------------
// atfc_checker
// Port-level assertions for the allocation tracker, bound to the top level.
// ----------------------------------------------------------------------------
module atfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input atfc_pkg::out_t out_data_o
);

  import atfc_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // after a transaction the block is either busy or shows its result
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o || in_stall_o)
    else $error("transaction accepted but neither busy nor result pending");

  a_err_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_kind != ERR_NONE) |-> !out_data_o.ok)
    else $error("error reported with ok set");

  // a counted error never shows a zero count
  a_err_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_kind == ERR_DOUBLE ||
                    out_data_o.error_kind == ERR_INVALID)
    |-> out_data_o.errors_seen != '0)
    else $error("free error with zero error count");

endmodule

bind allocation_tracker_free_checker_core atfc_checker u_atfc_checker (.*);
